// ===== sv/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none
package dq_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [2:0] {
    CMD_PEEK       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } dq_cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_SHIFT_UP   = 2'd1,
    OP_SHIFT_DOWN = 2'd2,
    OP_WRITE      = 2'd3
  } dq_op_t;

  typedef struct packed {
    dq_op_t                   op;
    logic signed [DATA_W-1:0] data;
  } dq_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue built from two rows of cells.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ----------------------------------
//   command   in_cmd, in_value                    start high while busy low
//   result    out_* (both ends, count, flags)     out_valid for one cycle, no stall
//
// One command is accepted per clock cycle while busy is low; its result word
// appears on the result ports in the cycle after acceptance, for exactly one
// cycle. The cell rows shift, write or hold all their entries at the same
// clock edge. Reset is synchronous and active low; busy is high during reset
// and for the cycle in which reset is released, and low afterwards. The
// receiver cannot stall, so nothing ever waits inside the block.
//
// The queue is kept twice. The front row holds the entries in order from the
// front, so cell zero is the front entry; the back row holds them in order
// from the back, so its cell zero is the back entry. A push at one end shifts
// that end's row up by one and writes the word at slot count of the other
// row. A pop at one end shifts that end's row down and merely shortens the
// other row through the count. Both reported ends thus come straight from a
// cell, with no read multiplexer over the entries.
`default_nettype none
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_cmd,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_front_value,
  output logic signed [DATA_W-1:0]      out_back_value,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic                          out_is_empty,
  output logic                          out_push_dropped
);

  logic             busy_r;
  logic             valid_r;
  logic             valid_nxt;
  logic             dropped_r;
  logic             dropped_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  dq_ctrl_t         f_ctrl;
  dq_ctrl_t         b_ctrl;
  logic signed [DATA_W-1:0] f_head;
  logic signed [DATA_W-1:0] b_head;

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // Command decode: choose what each row does and the new entry count.
  always_comb begin
    f_ctrl.op   = OP_HOLD;
    f_ctrl.data = in_value;
    b_ctrl.op   = OP_HOLD;
    b_ctrl.data = in_value;
    count_nxt   = count_r;
    dropped_nxt = 1'b0;
    valid_nxt   = accept;
    if (accept) begin
      case (in_cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            f_ctrl.op = OP_SHIFT_UP;
            b_ctrl.op = OP_WRITE;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            f_ctrl.op = OP_WRITE;
            b_ctrl.op = OP_SHIFT_UP;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (!empty) begin
            f_ctrl.op = OP_SHIFT_DOWN;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (!empty) begin
            b_ctrl.op = OP_SHIFT_DOWN;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          // Peek and the unused codes leave the queue as it is.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      valid_r   <= 1'b0;
      dropped_r <= 1'b0;
      count_r   <= '0;
    end else begin
      busy_r    <= 1'b0;
      valid_r   <= valid_nxt;
      dropped_r <= dropped_nxt;
      count_r   <= count_nxt;
    end
  end

  dq_row #(
    .DEPTH (CAPACITY),
    .CNT_W (CNT_W)
  ) u_front_row (
    .clk     (clk),
    .ctrl    (f_ctrl),
    .wr_slot (count_r),
    .head    (f_head)
  );

  dq_row #(
    .DEPTH (CAPACITY),
    .CNT_W (CNT_W)
  ) u_back_row (
    .clk     (clk),
    .ctrl    (b_ctrl),
    .wr_slot (count_r),
    .head    (b_head)
  );

  // The cells and the count already hold the state after the last command,
  // so the result word is read directly from them in the cycle after it.
  assign busy             = busy_r;
  assign out_valid        = valid_r;
  assign out_front_value  = empty ? EMPTY_VALUE : f_head;
  assign out_back_value   = empty ? EMPTY_VALUE : b_head;
  assign out_entry_count  = count_r;
  assign out_is_empty     = empty;
  assign out_push_dropped = dropped_r;

endmodule
`default_nettype wire

// ===== sv/dq_cell.sv =====
// One storage cell of a queue row: holds a word and trades it with its neighbors.
`default_nettype none
module dq_cell
  import dq_pkg::*;
(
  input  wire logic                     clk,
  input  wire dq_ctrl_t                 ctrl,
  input  wire logic                     sel,
  input  wire logic signed [DATA_W-1:0] lower_d,
  input  wire logic signed [DATA_W-1:0] upper_d,
  output logic signed [DATA_W-1:0]      q
);

  logic signed [DATA_W-1:0] word_r;
  logic signed [DATA_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctrl.op)
      OP_SHIFT_UP:   word_nxt = lower_d;
      OP_SHIFT_DOWN: word_nxt = upper_d;
      OP_WRITE:      if (sel) word_nxt = ctrl.data;
      default:       word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule
`default_nettype wire

// ===== sv/dq_row.sv =====
// A row of queue cells with its head at cell zero.
`default_nettype none
module dq_row
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire dq_ctrl_t                 ctrl,
  input  wire logic [CNT_W-1:0]         wr_slot,
  output logic signed [DATA_W-1:0]      head
);

  logic signed [DATA_W-1:0] q   [DEPTH];
  logic signed [DATA_W-1:0] low [DEPTH];
  logic signed [DATA_W-1:0] up  [DEPTH];
  logic [DEPTH-1:0]         sel;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // Each cell recognizes its own slot number on the broadcast write slot.
    assign sel[i] = (wr_slot == CNT_W'(i));

    if (i == 0) begin : g_first
      assign low[i] = ctrl.data;
    end else begin : g_mid_low
      assign low[i] = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign up[i] = '0;
    end else begin : g_mid_up
      assign up[i] = q[i+1];
    end

    dq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .sel     (sel[i]),
      .lower_d (low[i]),
      .upper_d (up[i]),
      .q       (q[i])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire

// ===== sv/dq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
`default_nettype none
module dq_checker
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [2:0]               in_cmd,
  input wire logic                     out_valid,
  input wire logic signed [DATA_W-1:0] out_front_value,
  input wire logic signed [DATA_W-1:0] out_back_value,
  input wire logic [CNT_W-1:0]         out_entry_count,
  input wire logic                     out_is_empty,
  input wire logic                     out_push_dropped
);

  // Every accepted command yields exactly one result word in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result strobe does not follow an accepted command");

  // An empty queue reports minus one at both ends.
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_front_value == EMPTY_VALUE && out_back_value == EMPTY_VALUE))
    else $error("empty queue shows a value at an end");

  // A refused push only happens for a push into a full queue.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_push_dropped) |->
      (out_entry_count == CNT_W'(CAPACITY) &&
       ($past(in_cmd) == CMD_PUSH_FRONT || $past(in_cmd) == CMD_PUSH_BACK)))
    else $error("push refused without a full queue");

  // The count moves by at most one between consecutive results.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_valid && $past(out_valid)) |->
      (out_entry_count == $past(out_entry_count) ||
       out_entry_count == $past(out_entry_count) + CNT_W'(1) ||
       out_entry_count == $past(out_entry_count) - CNT_W'(1)))
    else $error("entry count jumped by more than one");

  // The count never exceeds the capacity.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind double_ended_queue_top dq_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_dq_checker (.*);
`default_nettype wire
